// File: sv/tcw_pkg.sv
package tcw_pkg;

   // screen geometry defaults
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // item modes
   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // character codes with special meaning
   localparam logic [7:0] CODE_NEWLINE   = 8'd10;
   localparam logic [7:0] CODE_BACKSPACE = 8'd8;
   localparam logic [7:0] CODE_SPACE     = 8'd32;

   // register file
   localparam logic       REG_ATTR       = 1'b0;
   localparam logic [7:0] ATTR_RESET     = 8'd7;

endpackage

// File: sv/tcw_screen_mem.sv
module tcw_screen_mem #(
   parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] cells_ff [DEPTH];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tcw_seq.sv
module tcw_seq #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS,
   parameter int CELLS   = COLUMNS * ROWS,
   parameter int AW      = $clog2(CELLS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    attr,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_mode,
   input  logic [7:0]    req_char_code,
   input  logic [10:0]   req_cell_index,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_read_data,
   output logic [6:0]    rsp_cursor_column,
   output logic [4:0]    rsp_cursor_row,
   output logic          rsp_scrolled,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [15:0]   mem_wr_data,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [15:0]   mem_rd_data
);

   localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDWAIT = 3'd1;
   localparam logic [2:0] S_SCROLL = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          mv_valid_ff, mv_valid_in;
   logic [AW-1:0] mv_dst_ff, mv_dst_in;
   logic          scroll_flag_ff, scroll_flag_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic [6:0]    rsp_col_ff, rsp_col_in;
   logic [4:0]    rsp_row_ff, rsp_row_in;
   logic          rsp_scr_ff, rsp_scr_in;

   logic          accept;
   logic          adv_row;
   logic          load_rsp;
   logic [15:0]   load_data;
   logic          load_scr;
   logic [15:0]   blank;
   logic [AW-1:0] cur_addr;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign blank     = {attr, tcw_pkg::CODE_SPACE};
   assign cur_addr  = base_ff + AW'(col_ff);

   // sequencer and cursor
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      base_in        = base_ff;
      cnt_in         = cnt_ff;
      mv_valid_in    = 1'b0;
      mv_dst_in      = mv_dst_ff;
      scroll_flag_in = scroll_flag_ff;
      hit_in         = hit_ff;
      adv_row        = 1'b0;
      load_rsp       = 1'b0;
      load_data      = 16'd0;
      load_scr       = 1'b0;
      mem_rd_addr    = cnt_ff;
      // moved word of the scroll lands one row up
      mem_wr_en      = mv_valid_ff;
      mem_wr_addr    = mv_dst_ff;
      mem_wr_data    = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  tcw_pkg::MODE_PUT: begin
                     if (req_char_code == tcw_pkg::CODE_NEWLINE) begin
                        col_in  = '0;
                        adv_row = 1'b1;
                     end else if (req_char_code == tcw_pkg::CODE_BACKSPACE) begin
                        if (col_ff != '0) begin
                           col_in      = col_ff - 1'b1;
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = cur_addr - 1'b1;
                           mem_wr_data = blank;
                        end
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cur_addr;
                        mem_wr_data = {attr, req_char_code};
                        if (col_ff == LAST_COL) begin
                           col_in  = '0;
                           adv_row = 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     if (adv_row && (row_ff == LAST_ROW)) begin
                        state_in       = S_SCROLL;
                        cnt_in         = COL_STEP;
                        scroll_flag_in = 1'b1;
                     end else begin
                        if (adv_row) begin
                           row_in  = row_ff + 1'b1;
                           base_in = base_ff + COL_STEP;
                        end
                        load_rsp = 1'b1;
                     end
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     col_in         = '0;
                     row_in         = '0;
                     base_in        = '0;
                     cnt_in         = '0;
                     scroll_flag_in = 1'b0;
                     state_in       = S_FILL;
                  end
                  tcw_pkg::MODE_READ: begin
                     mem_rd_addr = AW'(req_cell_index);
                     hit_in      = (32'(req_cell_index) < CELLS);
                     state_in    = S_RDWAIT;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            load_rsp  = 1'b1;
            load_data = hit_ff ? mem_rd_data : 16'd0;
            state_in  = S_IDLE;
         end
         S_SCROLL: begin
            mem_rd_addr = cnt_ff;
            mv_valid_in = 1'b1;
            mv_dst_in   = cnt_ff - COL_STEP;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            cnt_in   = LAST_BASE;
            state_in = S_FILL;
         end
         S_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = blank;
            if (cnt_ff == LAST_CELL) begin
               load_rsp = 1'b1;
               load_scr = scroll_flag_ff;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
         rsp_col_in   = 7'(col_in);
         rsp_row_in   = 5'(row_in);
         rsp_scr_in   = load_scr;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         mv_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         mv_valid_ff  <= mv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_dst_ff      <= mv_dst_in;
      scroll_flag_ff <= scroll_flag_in;
      hit_ff         <= hit_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_scr_ff     <= rsp_scr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_scrolled      = rsp_scr_ff;

endmodule

// File: sv/text_console_writer_core.sv
// Character-cell text console: a COLUMNS x ROWS screen of 16-bit words
// (attribute high byte, character low byte) in one simple dual-port memory
// with a registered read, plus a cursor. An ordinary character writes one
// memory word, a backspace off column 0 blanks one and a newline writes
// none; unless it scrolls, its result word is in the result register at the
// edge that takes it. A cell read passes the memory read register and then
// the result register. A put that runs past the last row scrolls: the screen
// moves up one row at one word per cycle through the memory and the bottom
// row is then blanked. A clear writes every cell. The input stalls during a
// cell read, a scroll or a clear, and a new word is taken only once the
// result register is free or being emptied. The screen holds no defined
// value after reset; only cells written since reset may be read. The
// attribute register sits at byte address 0 and resets to 7.
module text_console_writer_core #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic        rsp_scrolled,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [7:0]    attr_ff, attr_in;
   logic          attr_sel;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [15:0]   mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [15:0]   mem_rd_data;

   // register port
   assign csr_pready = 1'b1;
   assign attr_sel   = (csr_paddr[2] == tcw_pkg::REG_ATTR);

   always_comb begin
      attr_in = attr_ff;
      if (csr_psel && csr_penable && csr_pwrite && attr_sel) begin
         attr_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign csr_prdata = attr_sel ? {24'd0, attr_ff} : 32'd0;

   tcw_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELLS   (CELLS),
      .AW      (AW)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .attr              (attr_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_scrolled      (rsp_scrolled),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   tcw_screen_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: tb/tb_text_console_writer_core.sv
`timescale 1ns / 100ps

module tb_text_console_writer_core;

   localparam int SCREEN_COLS  = tcw_pkg::DEF_COLUMNS;
   localparam int SCREEN_ROWS  = tcw_pkg::DEF_ROWS;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] ATTR_ADDR   = {tcw_pkg::REG_ATTR, 2'b00};
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int SETTLE       = 8;
   localparam int PHASE_WORDS  = 133;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  code;
      logic [10:0] index;
   } console_word_type;

   typedef struct packed {
      logic [15:0] data;
      logic [6:0]  col;
      logic [4:0]  row;
      logic        scrolled;
   } console_view_type;

   // dut ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [7:0]  req_char_code = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_read_data;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic        rsp_scrolled;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // screen and cursor as the testbench sees them
   bit [15:0]   screen_model [SCREEN_CELLS];
   int          cur_col = 0;
   int          cur_row = 0;
   logic [7:0]  attr_model = tcw_pkg::ATTR_RESET;

   console_word_type words_to_send [$];
   console_view_type expected_views [$];
   console_word_type word_on_bus;
   console_view_type outcome;
   console_view_type want;

   int words_queued = 0;
   int busy_words = 0;
   int words_sent = 0;
   int words_checked = 0;
   int error_count = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_hold = 0;
   int rsp_calm = 0;
   int read_tally = 0;
   int clear_tally = 0;
   int scroll_tally = 0;
   int ignored_tally = 0;

   text_console_writer_core #(
      .COLUMNS(SCREEN_COLS),
      .ROWS(SCREEN_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .req_cell_index(req_cell_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_cursor_column(rsp_cursor_column),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_scrolled(rsp_scrolled),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // apply one word to the screen copy and work out its result
   function automatic void console_apply(input console_word_type w,
                                         output console_view_type v);
      bit rolled;
      rolled = 1'b0;
      v = '0;
      case (w.mode)
         tcw_pkg::MODE_PUT: begin
            if (w.code == tcw_pkg::CODE_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (w.code == tcw_pkg::CODE_BACKSPACE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen_model[cur_row * SCREEN_COLS + cur_col] =
                     {attr_model, tcw_pkg::CODE_SPACE};
               end
            end else begin
               screen_model[cur_row * SCREEN_COLS + cur_col] = {attr_model, w.code};
               cur_col++;
               if (cur_col >= SCREEN_COLS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            // past the last row: move everything up and blank the bottom row
            if (cur_row >= SCREEN_ROWS) begin
               cur_row = SCREEN_ROWS - 1;
               for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                  screen_model[i] = screen_model[i + SCREEN_COLS];
               for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                  screen_model[i] = {attr_model, tcw_pkg::CODE_SPACE};
               rolled = 1'b1;
            end
         end
         tcw_pkg::MODE_CLEAR: begin
            for (int i = 0; i < SCREEN_CELLS; i++)
               screen_model[i] = {attr_model, tcw_pkg::CODE_SPACE};
            cur_col = 0;
            cur_row = 0;
         end
         tcw_pkg::MODE_READ: begin
            if (w.index < SCREEN_CELLS)
               v.data = screen_model[w.index];
         end
         default: ;
      endcase
      v.col = cur_col[6:0];
      v.row = cur_row[4:0];
      v.scrolled = rolled;
   endfunction

   // per-word wait, with occasional stretches of no waiting at all
   function automatic int next_pause(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int exp_val);
      error_count++;
      $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
               what, words_checked, got, exp_val);
   endtask

   task automatic queue_word(input logic [1:0] mode, input logic [7:0] code,
                             input logic [10:0] index);
      console_word_type w;
      w.mode = mode;
      w.code = code;
      w.index = index;
      words_to_send.push_back(w);
      words_queued++;
      if (mode != MODE_UNUSED)
         busy_words++;
   endtask

   // lines of random text with backspaces, reads and unused words, newline runs and the odd clear
   task automatic queue_text_session(input int quota);
      int line_len;
      int pick;
      int start;
      start = busy_words;
      while (busy_words - start < quota) begin
         if ($urandom_range(0, 99) == 0)
            queue_word(tcw_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                       11'($urandom_range(0, 2047)));
         pick = $urandom_range(0, 19);
         if (pick >= 18) begin
            line_len = $urandom_range(3, 20);
            for (int k = 0; k < line_len; k++)
               queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_NEWLINE,
                          11'($urandom_range(0, 2047)));
         end else begin
            if (pick < 14)
               line_len = $urandom_range(0, 3);
            else if (pick < 17)
               line_len = $urandom_range(4, 40);
            else
               line_len = $urandom_range(78, 90);
            for (int k = 0; k < line_len; k++) begin
               pick = $urandom_range(0, 49);
               if (pick < 5)
                  queue_word(tcw_pkg::MODE_READ, 8'($urandom_range(0, 255)),
                             11'(($urandom_range(0, 9) == 0)
                                 ? $urandom_range(SCREEN_CELLS, 2047)
                                 : $urandom_range(0, SCREEN_CELLS - 1)));
               else if (pick < 8)
                  queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_BACKSPACE,
                             11'($urandom_range(0, 2047)));
               else if (pick == 8)
                  queue_word(MODE_UNUSED, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
               else
                  queue_word(tcw_pkg::MODE_PUT, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end
            if ($urandom_range(0, 9) != 0)
               queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_NEWLINE,
                          11'($urandom_range(0, 2047)));
         end
      end
   endtask

   // wait until every queued word has been taken and answered
   task automatic wait_drained;
      while (words_sent != words_queued || expected_views.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // attribute write followed by a read back
   task automatic attr_write(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ATTR_ADDR;
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      attr_model = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value)
         flag_mismatch("attribute read back", int'(csr_prdata[7:0]), int'(value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // driver: present queued words, predict at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            console_apply(word_on_bus, outcome);
            expected_views.push_back(outcome);
            words_sent++;
            case (word_on_bus.mode)
               tcw_pkg::MODE_READ:  read_tally++;
               tcw_pkg::MODE_CLEAR: clear_tally++;
               MODE_UNUSED: ignored_tally++;
               default: ;
            endcase
            if (outcome.scrolled)
               scroll_tally++;
            req_gap = next_pause(req_calm);
         end
         if (req_valid && !req_ready) begin
            // hold the word until taken
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (words_to_send.size() > 0) begin
            word_on_bus = words_to_send.pop_front();
            req_valid <= 1'b1;
            req_mode <= word_on_bus.mode;
            req_char_code <= word_on_bus.code;
            req_cell_index <= word_on_bus.index;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               flag_mismatch("result with nothing pending", int'(rsp_read_data), 0);
            end else begin
               want = expected_views.pop_front();
               if (rsp_read_data !== want.data)
                  flag_mismatch("read_data", int'(rsp_read_data), int'(want.data));
               if (rsp_cursor_column !== want.col)
                  flag_mismatch("cursor_column", int'(rsp_cursor_column), int'(want.col));
               if (rsp_cursor_row !== want.row)
                  flag_mismatch("cursor_row", int'(rsp_cursor_row), int'(want.row));
               if (rsp_scrolled !== want.scrolled)
                  flag_mismatch("scrolled", int'(rsp_scrolled), int'(want.scrolled));
            end
            words_checked++;
            rsp_hold = next_pause(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_views.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] attr_plan [4];
      attr_plan[0] = 8'hFF;
      attr_plan[1] = 8'h00;
      attr_plan[2] = 8'($urandom_range(0, 255));
      attr_plan[3] = 8'($urandom_range(0, 255));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset attribute; only written cells are read
      queue_word(tcw_pkg::MODE_PUT, 8'h48, 11'h7FF);
      queue_word(tcw_pkg::MODE_PUT, 8'h00, 11'h000);
      queue_word(tcw_pkg::MODE_PUT, 8'hFF, 11'h7FF);
      queue_word(tcw_pkg::MODE_PUT, 8'h80, 11'h000);
      queue_word(tcw_pkg::MODE_READ, 8'hFF, 11'd0);
      queue_word(tcw_pkg::MODE_READ, 8'h00, 11'd2);
      queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_BACKSPACE, 11'h000);
      queue_word(tcw_pkg::MODE_READ, 8'h00, 11'd3);
      queue_word(tcw_pkg::MODE_READ, 8'h00, 11'(SCREEN_CELLS));
      queue_word(tcw_pkg::MODE_READ, 8'h00, 11'h7FF);
      queue_word(MODE_UNUSED, 8'hFF, 11'h7FF);
      queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_NEWLINE, 11'h000);
      // backspace at column 0 leaves everything alone
      queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_BACKSPACE, 11'h7FF);
      queue_word(tcw_pkg::MODE_PUT, tcw_pkg::CODE_SPACE, 11'h000);
      queue_word(tcw_pkg::MODE_READ, 8'h00, 11'(SCREEN_COLS));
      queue_word(tcw_pkg::MODE_CLEAR, 8'hFF, 11'h7FF);
      queue_word(tcw_pkg::MODE_READ, 8'h00, 11'(SCREEN_CELLS - 1));
      queue_word(tcw_pkg::MODE_READ, 8'hFF, 11'd0);
      wait_drained();

      // random sessions, one per attribute setting
      for (int p = 0; p < 4; p++) begin
         attr_write(attr_plan[p]);
         queue_text_session(PHASE_WORDS);
         wait_drained();
      end

      $display("covered %0d words: %0d reads, %0d clears, %0d scrolls, %0d ignored",
               words_sent, read_tally, clear_tally, scroll_tally, ignored_tally);
      $display("attribute settings: reset value, 0xff, 0x00, 0x%0h, 0x%0h; %0d mismatches",
               attr_plan[2], attr_plan[3], error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: text_console_writer_core.f
sv/tcw_pkg.sv
sv/tcw_screen_mem.sv
sv/tcw_seq.sv
sv/text_console_writer_core.sv
tb/tb_text_console_writer_core.sv
